// ===== sv/bitmap_frame_allocator_assert.svh =====
// Assertion macros for the bitmap frame allocator.
// Used by the top level only; no dependencies.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// Check that a property holds after reset.
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, including during reset.
`define BFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bfa_pkg.sv =====
// Package for the bitmap frame allocator: defaults, request modes and states.
// No dependencies.
package bfa_pkg;

  localparam int unsigned MaxFramesDef  = 32768;
  localparam int unsigned FrameBytesDef = 4096;
  localparam int unsigned WordBitsDef   = 32;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_ALLOC1  = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_RESERVE = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN_RD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_LD,
    ST_MARK,
    ST_FINISH,
    ST_OUT
  } state_e;

endpackage

// ===== sv/bfa_if.sv =====
// Valid/ready channel interfaces for the bitmap frame allocator.
// Depends on bfa_pkg.
interface bfa_req_if
  import bfa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [AddrW-1:0]  address;
  logic [CountW-1:0] count;
  logic [AddrW-1:0]  limit_address;
  modport source (output valid, mode, address, count, limit_address, input ready);
  modport sink   (input valid, mode, address, count, limit_address, output ready);
endinterface

interface bfa_rsp_if
  import bfa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [AddrW-1:0]  result_address;
  logic [CountW-1:0] used_count;
  modport source (output valid, ok, result_address, used_count, input ready);
  modport sink   (input valid, ok, result_address, used_count, output ready);
endinterface

// ===== sv/bitmap_frame_allocator.sv =====
// Bitmap frame allocator top level: sequencer, bitmap memory, free counter.
// Depends on bfa_pkg, bfa_if and bitmap_frame_allocator_assert.svh.
//
// Usage:
//  - req (sink): one request transfer carries mode, address, count and
//    limit_address. rsp (source): one response transfer per request with
//    ok, result_address and used_count.
//  - cfg_we_i/cfg_wdata_i write frame_count; write only while idle.
//  - After reset the block sweeps the bitmap to all-used, one word per
//    cycle; req.ready is low during that pass. Free counter and
//    frame_count reset to zero.
//  - Requests are handled one at a time by a single bit-walk unit that tests
//    or sets one bitmap bit per cycle between word reads; req.ready is high
//    only while idle. A request that fails its precheck (allocate with zero
//    count or too few free frames, allocate-one with no free frame) goes from
//    idle straight to the finish state and then to the output register. Any
//    other request passes setup and then, as its mode needs, the scan (a word
//    read for each word entered) and the mark pass (a read and a load for
//    each word touched). The next request can be taken in the cycle after
//    the response transfer; the bit walk sets the rate.
//  - When the receiver stalls, the response holds in the output register
//    and no new request is taken until it is transferred.
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES  = MaxFramesDef,
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned WORD_BITS   = WordBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  bfa_req_if.sink           req,
  bfa_rsp_if.source         rsp
);
`include "bitmap_frame_allocator_assert.svh"

  localparam int unsigned Words = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW   = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW    = $clog2(WORD_BITS);
  localparam int unsigned FW    = $clog2(MAX_FRAMES + 1) + 1;  // frame idx + room
  localparam int unsigned SHW   = $clog2(FRAME_BYTES);
  localparam int unsigned FXW   = (FW > AddrW - SHW + 1) ? FW : AddrW - SHW + 1;

  logic [WORD_BITS-1:0] mem_q [Words];
  logic [WORD_BITS-1:0] rdata_q, word_q, word_d;

  state_e state_q, state_d;
  logic [CountW-1:0] fcount_q;
  logic [CountW-1:0] free_q, free_d;
  logic [FXW-1:0]    pos_q, pos_d;     // current frame
  logic [FXW-1:0]    bound_q, bound_d; // scan/mark end (exclusive)
  logic [FXW-1:0]    start_q, start_d;
  logic [CountW:0]   run_q, run_d;
  mode_e             mode_q;
  logic [CountW-1:0] cnt_q;
  logic              ok_q, ok_d;
  logic [AddrW-1:0]  raddr_q, raddr_d;
  logic [CountW-1:0] used_q, used_d;
  logic [WAW-1:0]    clr_q;

  logic                 mem_we;
  logic [WAW-1:0]       mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [FXW-1:0]    n_frames;
  logic [FXW-1:0]    first_fr, limit_fr;
  logic [FXW-1:0]    pos_inc, run_start;
  logic [BW-1:0]     bit_idx;
  logic [WAW-1:0]    word_idx;
  logic              cur_used;
  logic              last_step, word_end;
  logic [FXW:0]      sum_fr, run_end;

  assign n_frames  = (FXW'(fcount_q) < FXW'(MAX_FRAMES)) ? FXW'(fcount_q)
                                                          : FXW'(MAX_FRAMES);
  assign first_fr  = FXW'(req.address >> SHW);
  assign limit_fr  = FXW'(req.limit_address >> SHW);
  assign run_end   = (FXW + 1)'(first_fr) + (FXW + 1)'(req.count);
  assign bit_idx   = pos_q[BW-1:0];
  assign word_idx  = WAW'(pos_q >> BW);
  assign cur_used  = rdata_q[bit_idx];
  assign pos_inc   = pos_q + 1'b1;
  assign last_step = (pos_inc >= bound_q);
  assign word_end  = (pos_inc[BW-1:0] == '0);
  assign run_start = (run_q == '0) ? pos_q : start_q;

  // Bitmap memory: one write port, one registered read port at the word of
  // the current frame.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[word_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      fcount_q <= '0;
      free_q   <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        fcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    bound_q <= bound_d;
    start_q <= start_d;
    run_q   <= run_d;
    word_q  <= word_d;
    ok_q    <= ok_d;
    raddr_q <= raddr_d;
    used_q  <= used_d;
    if (req.valid && req.ready) begin
      mode_q <= mode_e'(req.mode);
      cnt_q  <= req.count;
    end
  end

  assign sum_fr = (FXW + 1)'(free_q) + (FXW + 1)'(cnt_q);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    bound_d   = bound_q;
    start_d   = start_q;
    run_d     = run_q;
    word_d    = word_q;
    ok_d      = ok_q;
    raddr_d   = raddr_q;
    used_d    = used_q;
    free_d    = free_q;
    mem_we    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == WAW'(Words - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          ok_d    = 1'b0;
          raddr_d = '0;
          run_d   = '0;
          start_d = '0;
          case (mode_e'(req.mode))
            MODE_ALLOC: begin
              pos_d   = '0;
              bound_d = n_frames;
              if (req.count == '0 || free_q < req.count) begin
                state_d = ST_FINISH;
              end else begin
                state_d = ST_SETUP;
              end
            end
            MODE_ALLOC1: begin
              pos_d   = '0;
              bound_d = (limit_fr > n_frames) ? n_frames : limit_fr;
              if (free_q == '0) begin
                state_d = ST_FINISH;
              end else begin
                state_d = ST_SETUP;
              end
            end
            default: begin
              // Release/reserve: clip the run to the managed range.
              pos_d = first_fr;
              if (run_end > (FXW + 1)'(n_frames)) begin
                bound_d = n_frames;
              end else begin
                bound_d = FXW'(run_end);
              end
              state_d = ST_SETUP;
            end
          endcase
        end
      end
      ST_SETUP: begin
        if (pos_q >= bound_q) begin
          state_d = ST_FINISH;
        end else if (mode_q == MODE_RELEASE || mode_q == MODE_RESERVE) begin
          state_d = ST_MARK_RD;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN;  // address presented, data next
      end
      ST_SCAN: begin
        // Test one bit of the word held in the read register.
        if (mode_q == MODE_ALLOC1) begin
          if (!cur_used) begin
            ok_d    = 1'b1;
            start_d = pos_q;
            bound_d = pos_inc;
            state_d = ST_MARK_RD;
          end else if (last_step) begin
            state_d = ST_FINISH;
          end else begin
            pos_d = pos_inc;
            if (word_end) begin
              state_d = ST_SCAN_RD;
            end
          end
        end else begin
          if (cur_used) begin
            run_d = '0;
          end else begin
            start_d = run_start;
            run_d   = run_q + 1'b1;
          end
          if (!cur_used && (run_q + 1'b1) == {1'b0, cnt_q}) begin
            // Run complete: go back to its first frame and mark it.
            ok_d    = 1'b1;
            pos_d   = run_start;
            bound_d = pos_inc;
            state_d = ST_MARK_RD;
          end else if (last_step) begin
            state_d = ST_FINISH;
          end else begin
            pos_d = pos_inc;
            if (word_end) begin
              state_d = ST_SCAN_RD;
            end
          end
        end
      end
      ST_MARK_RD: begin
        state_d = ST_MARK_LD;
      end
      ST_MARK_LD: begin
        word_d  = rdata_q;
        state_d = ST_MARK;
      end
      ST_MARK: begin
        // Set or clear one bit per cycle; write the word back when leaving it.
        word_d          = word_q;
        word_d[bit_idx] = (mode_q != MODE_RELEASE);
        pos_d           = pos_inc;
        if (last_step || word_end) begin
          mem_we = 1'b1;
          if (last_step) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_MARK_RD;
          end
        end
      end
      ST_FINISH: begin
        state_d = ST_OUT;
        case (mode_q)
          MODE_ALLOC: begin
            if (ok_q) begin
              free_d  = free_q - cnt_q;
              raddr_d = AddrW'(start_q) << SHW;
            end
          end
          MODE_ALLOC1: begin
            if (ok_q) begin
              free_d  = free_q - 1'b1;
              raddr_d = AddrW'(start_q) << SHW;
            end
          end
          MODE_RESERVE: begin
            free_d = (free_q > cnt_q) ? free_q - cnt_q : '0;
            ok_d   = 1'b1;
          end
          default: begin
            free_d = (sum_fr > (FXW + 1)'(n_frames)) ? CountW'(n_frames) : CountW'(sum_fr);
            ok_d   = 1'b1;
          end
        endcase
        used_d = (FXW'(free_d) <= n_frames) ? CountW'(n_frames - FXW'(free_d)) : '0;
      end
      ST_OUT: begin
        if (rsp.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Single write port: clearing pass after reset, else mark write-back.
    mem_waddr = word_idx;
    mem_wdata = word_d;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '1;
    end
  end

  assign req.ready          = (state_q == ST_IDLE);
  assign rsp.valid          = (state_q == ST_OUT);
  assign rsp.ok             = ok_q;
  assign rsp.result_address = raddr_q;
  assign rsp.used_count     = used_q;

  `BFA_ASSERT(a_no_overlap, clk_i, rst_ni, !(req.ready && rsp.valid), "busy overlap")
  `BFA_ASSERT(a_out_hold, clk_i, rst_ni, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable({rsp.ok, rsp.result_address, rsp.used_count})), "resp dropped")
  `BFA_ASSERT(a_fail_addr, clk_i, rst_ni, rsp.valid |-> (rsp.ok || rsp.result_address == '0), "failed request with address")
  `BFA_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |=> (state_q == ST_CLEAR || rst_ni), "reset state")

endmodule

// ===== bench/tb.sv =====
// Testbench for bitmap_frame_allocator: directed and random request transfers
// checked field by field against a behavioral first-fit frame allocator.
// Depends on bfa_pkg, bfa_if and the allocator RTL.
module tb
  import bfa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumFrames = MaxFramesDef;
  localparam int unsigned PageBytes = FrameBytesDef;
  localparam int unsigned StallLimit = 400000;

  typedef struct packed {
    mode_e             mode;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  limit_address;
  } frame_req_t;

  typedef struct packed {
    logic              ok;
    logic [AddrW-1:0]  result_address;
    logic [CountW-1:0] used_count;
  } frame_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  bfa_req_if req ();
  bfa_rsp_if rsp ();

  bitmap_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp)
  );

  // Mirror of the allocator state
  bit          frame_used [NumFrames];
  int unsigned free_cnt;
  int unsigned frame_reg;

  frame_req_t  pending_reqs [$];
  frame_rsp_t  expected_rsps [$];

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_token;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;

  function automatic int unsigned active_frames();
    return (frame_reg < NumFrames) ? frame_reg : NumFrames;
  endfunction

  // Apply one request to the mirror and return what the block must answer.
  function automatic frame_rsp_t apply_request(frame_req_t r);
    frame_rsp_t  res;
    int unsigned n;
    int unsigned run;
    int unsigned start;
    longint unsigned bound;
    longint unsigned first;
    longint unsigned sum;
    n = active_frames();
    res = '0;
    run = 0;
    start = 0;
    case (r.mode)
      MODE_ALLOC: begin
        if (r.count != 0 && free_cnt >= r.count) begin
          for (int unsigned f = 0; f < n; f++) begin
            if (frame_used[f]) begin
              run = 0;
            end else begin
              if (run == 0) start = f;
              run++;
              if (run == r.count) break;
            end
          end
          if (run == r.count) begin
            for (int unsigned i = 0; i < r.count; i++) frame_used[start + i] = 1'b1;
            free_cnt -= r.count;
            res.ok = 1'b1;
            res.result_address = start * PageBytes;
          end
        end
      end
      MODE_ALLOC1: begin
        bound = r.limit_address / PageBytes;
        if (bound > n) bound = n;
        if (free_cnt != 0) begin
          for (int unsigned f = 0; f < bound; f++) begin
            if (!frame_used[f]) begin
              frame_used[f] = 1'b1;
              free_cnt -= 1;
              res.ok = 1'b1;
              res.result_address = f * PageBytes;
              break;
            end
          end
        end
      end
      default: begin
        first = r.address / PageBytes;
        for (longint unsigned i = 0; i < r.count; i++) begin
          if (first + i < n) frame_used[first + i] = (r.mode == MODE_RESERVE);
        end
        if (r.mode == MODE_RESERVE) begin
          free_cnt = (free_cnt > r.count) ? free_cnt - r.count : 0;
        end else begin
          sum = free_cnt + r.count;
          free_cnt = int'((sum > n) ? n : sum);
        end
        res.ok = 1'b1;
      end
    endcase
    res.used_count = 16'((free_cnt <= n) ? n - free_cnt : 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic queue_req(mode_e m, logic [31:0] a, logic [15:0] c, logic [31:0] l);
    frame_req_t r;
    r.mode = m;
    r.address = a;
    r.count = c;
    r.limit_address = l;
    pending_reqs.push_back(r);
  endtask

  // Hold the sender until every outstanding response has been transferred.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req.valid)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_frame_count(int unsigned value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frame_reg = value & 16'hffff;
    @(posedge clk_i);
  endtask

  // Mostly well-formed traffic around the managed range, some raw noise.
  task automatic queue_random(int unsigned items);
    int unsigned n;
    int unsigned pick;
    logic [31:0] a;
    n = active_frames();
    for (int unsigned k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      a = $urandom_range(0, n + 4) * PageBytes + $urandom_range(0, PageBytes - 1);
      if (pick < 30) begin
        queue_req(MODE_ALLOC, $urandom, 16'(($urandom_range(0, 32) == 0) ? 0 :
                  $urandom_range(1, 8)), $urandom);
      end else if (pick < 50) begin
        queue_req(MODE_ALLOC1, $urandom, 16'($urandom),
                  ($urandom_range(0, 9) == 0) ? $urandom :
                  $urandom_range(0, n) * PageBytes + $urandom_range(0, PageBytes - 1));
      end else if (pick < 75) begin
        queue_req(MODE_RELEASE, a, 16'($urandom_range(1, 16)), $urandom);
      end else if (pick < 95) begin
        queue_req(MODE_RESERVE, a, 16'($urandom_range(1, 16)), $urandom);
      end else begin
        queue_req(mode_e'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, 63)),
                  $urandom);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: advance to the next pending request once the current one transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready)
        expected_rsps.push_back(apply_request({mode_e'(req.mode), req.address, req.count,
                                               req.limit_address}));
      if (!req.valid || req.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          frame_req_t r;
          r = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.mode <= r.mode;
          req.address <= r.address;
          req.count <= r.count;
          req.limit_address <= r.limit_address;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni)
      rsp.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: compare every response transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", rsp.result_address, 0);
      end else begin
        frame_rsp_t want;
        want = expected_rsps.pop_front();
        if (rsp.ok !== want.ok) report_mismatch("ok", rsp.ok, want.ok);
        if (rsp.result_address !== want.result_address)
          report_mismatch("result_address", rsp.result_address, want.result_address);
        if (rsp.used_count !== want.used_count)
          report_mismatch("used_count", rsp.used_count, want.used_count);
      end
    end
  end

  // Watchdog: stop when nothing transfers for too long.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_ALLOC;
    req.address = '0;
    req.count = '0;
    req.limit_address = '0;
    rsp.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    for (int unsigned f = 0; f < NumFrames; f++) frame_used[f] = 1'b1;
    free_cnt = 0;
    frame_reg = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing managed: allocate fails, zero-length allocate fails, free stays 0.
    queue_req(MODE_ALLOC, 0, 0, 0);
    queue_req(MODE_ALLOC, 0, 1, 0);
    queue_req(MODE_ALLOC1, 0, 0, 32'hffff_ffff);
    queue_req(MODE_RELEASE, 0, 4, 0);
    queue_req(MODE_RESERVE, 0, 4, 0);

    // Small map: exact fit, limit bound, out-of-range frames, saturation.
    write_frame_count(96);
    queue_req(MODE_RELEASE, 0, 96, 0);
    queue_req(MODE_RESERVE, 32 * PageBytes + 12'hfff, 32, 0);
    queue_req(MODE_ALLOC, 0, 40, 0);                // used word splits the run
    queue_req(MODE_ALLOC, 0, 32, 0);
    queue_req(MODE_ALLOC1, 0, 0, 0);                // bound zero
    queue_req(MODE_ALLOC1, 0, 0, 70 * PageBytes);
    queue_req(MODE_RELEASE, 32'hffff_ffff, 1, 0);   // frame far out of range
    queue_req(MODE_RELEASE, 90 * PageBytes, 20, 0); // run crosses the end
    queue_req(MODE_RESERVE, 0, 16'hffff, 0);        // floors at zero
    queue_req(MODE_ALLOC1, 0, 0, 32'hffff_ffff);
    queue_req(MODE_RELEASE, 0, 16'hffff, 0);        // caps at frame count
    queue_req(MODE_ALLOC, 0, 96, 0);                // free equals count
    queue_req(MODE_ALLOC, 0, 1, 0);

    // Frame count above the maximum: full-size map, largest runs.
    write_frame_count(16'hffff);
    queue_req(MODE_RELEASE, 0, 16'h8000, 0);
    queue_req(MODE_ALLOC, 0, 16'h8000, 0);
    queue_req(MODE_ALLOC1, 0, 0, 32'hffff_ffff);
    queue_req(MODE_RELEASE, (NumFrames - 1) * PageBytes, 1, 0);
    queue_req(MODE_ALLOC1, 0, 0, 32'hffff_ffff);
    drain();

    // Random phases, small maps to keep scans short.
    write_frame_count($urandom_range(32, 200));
    queue_req(MODE_RELEASE, 0, 16'hffff, 0);
    queue_random(300);
    drain();

    write_frame_count($urandom_range(32, 200));
    sender_idle_pct = 87;
    queue_random(300);
    drain();

    write_frame_count($urandom_range(32, 200));
    sender_idle_pct = 0;
    recv_stall_pct = 87;
    queue_random(300);
    drain();

    write_frame_count($urandom_range(32, 200));
    recv_stall_pct = 0;
    hold_token = hold_token + 1;  // fill the block while the receiver holds off
    queue_random(100);
    drain();
    sender_idle_pct = 20;
    recv_stall_pct = 20;
    queue_random(200);
    drain();

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
